// ===== rtl/core/scq_pkg.sv =====
// ----------------------------------------------------------------------------
// scq_pkg
// Shared constants and controller/datapath interface types for the serial
// command line queue.
// ----------------------------------------------------------------------------
package scq_pkg;

  // Default sizes
  localparam int LINE_CAPACITY_DEF = 64;
  localparam int QUEUE_SLOTS_DEF   = 8;

  // Opcodes of an input item
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Framing characters
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic take_byte;   // process in_rx_byte
    logic rd_len;      // read length of oldest slot, clear char counter
    logic rd_char;     // read next character into the output register
    logic load_empty;  // load zero into the output character
    logic pop_done;    // retire the oldest slot
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic queue_empty; // no queued line
    logic last_char;   // character counter sits on the final character
  } dp_sts_t;

endpackage

// ===== rtl/core/scq_datapath.sv =====
// ----------------------------------------------------------------------------
// scq_datapath
// Line assembly, slot ring pointers, slot character and length memories,
// and the output character register.
// ----------------------------------------------------------------------------
module scq_datapath #(
  parameter int LINE_CAPACITY = scq_pkg::LINE_CAPACITY_DEF,
  parameter int QUEUE_SLOTS   = scq_pkg::QUEUE_SLOTS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  scq_pkg::dp_cmd_t cmd,
  input  logic [7:0]      rx_byte,
  output scq_pkg::dp_sts_t sts,
  output logic [7:0]      line_char
);
  import scq_pkg::*;

  localparam int LW    = $clog2(LINE_CAPACITY);
  localparam int SW    = $clog2(QUEUE_SLOTS);
  localparam int DEPTH = 1 << (SW + LW);
  localparam logic [LW-1:0] LEN_MAX  = LW'(LINE_CAPACITY - 1);
  localparam logic [SW-1:0] SLOT_TOP = SW'(QUEUE_SLOTS - 1);

  // Characters are written straight into the slot that write_index points
  // at; that slot is never part of the queue until the line is pushed.
  logic [7:0]    slot_mem [DEPTH];
  logic [LW-1:0] len_mem  [QUEUE_SLOTS];

  logic [LW-1:0] line_length_r, line_length_nxt;
  logic          discard_r, discard_nxt;
  logic [SW-1:0] write_index_r, write_index_nxt;
  logic [SW-1:0] read_index_r, read_index_nxt;
  logic [LW-1:0] cnt_r;
  logic [LW-1:0] len_q_r;
  logic [7:0]    line_char_r;

  logic          char_wr;
  logic          push;
  logic [SW-1:0] wr_next;
  logic [SW-1:0] rd_next;

  assign wr_next = (write_index_r == SLOT_TOP) ? '0 : write_index_r + 1'b1;
  assign rd_next = (read_index_r == SLOT_TOP) ? '0 : read_index_r + 1'b1;

  // Frame received bytes into lines
  always_comb begin
    line_length_nxt = line_length_r;
    discard_nxt     = discard_r;
    write_index_nxt = write_index_r;
    read_index_nxt  = read_index_r;
    char_wr         = 1'b0;
    push            = 1'b0;
    if (cmd.take_byte) begin
      if (discard_r) begin
        if (rx_byte == CH_LF) begin
          discard_nxt     = 1'b0;
          line_length_nxt = '0;
        end
      end else if (rx_byte == CH_LF) begin
        if (line_length_r != '0) begin
          // drop the oldest line when the ring is full
          push            = 1'b1;
          write_index_nxt = wr_next;
          line_length_nxt = '0;
          if (wr_next == read_index_r) begin
            read_index_nxt = rd_next;
          end
        end
      end else if (rx_byte != CH_CR) begin
        if (line_length_r < LEN_MAX) begin
          char_wr         = 1'b1;
          line_length_nxt = line_length_r + 1'b1;
        end else begin
          line_length_nxt = '0;
          discard_nxt     = 1'b1;
        end
      end
    end
    if (cmd.pop_done) begin
      read_index_nxt = rd_next;
    end
  end

  // Hold framing state and ring pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_length_r <= '0;
      discard_r     <= 1'b0;
      write_index_r <= '0;
      read_index_r  <= '0;
    end else begin
      line_length_r <= line_length_nxt;
      discard_r     <= discard_nxt;
      write_index_r <= write_index_nxt;
      read_index_r  <= read_index_nxt;
    end
  end

  // Slot character memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (char_wr) begin
      slot_mem[{write_index_r, line_length_r}] <= rx_byte;
    end
    if (cmd.rd_char) begin
      line_char_r <= slot_mem[{read_index_r, cnt_r}];
    end else if (cmd.load_empty) begin
      line_char_r <= '0;
    end
  end

  // Slot length memory and character counter
  always_ff @(posedge clk) begin
    if (push) begin
      len_mem[write_index_r] <= line_length_r;
    end
    if (cmd.rd_len) begin
      len_q_r <= len_mem[read_index_r];
      cnt_r   <= '0;
    end else if (cmd.rd_char) begin
      cnt_r   <= cnt_r + 1'b1;
    end
  end

  assign sts.queue_empty = (read_index_r == write_index_r);
  assign sts.last_char   = (cnt_r == LW'(len_q_r - 1'b1));
  assign line_char       = line_char_r;

  // Checks
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    line_length_r <= LEN_MAX)
    else $error("line length beyond capacity");
  a_discard_len: assert property (@(posedge clk) disable iff (!rst_n)
    discard_r |-> line_length_r == '0)
    else $error("characters held while discarding");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop_done |-> !sts.queue_empty)
    else $error("pop retired a slot from an empty queue");

endmodule

// ===== rtl/core/scq_ctrl.sv =====
// ----------------------------------------------------------------------------
// scq_ctrl
// Controller: accepts items, sequences a pop through the length read and
// the character reads, and owns the result handshake.
// ----------------------------------------------------------------------------
module scq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_opcode,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_char_last,
  output logic             out_queue_empty,
  output scq_pkg::dp_cmd_t cmd,
  input  scq_pkg::dp_sts_t sts
);
  import scq_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LEN,
    ST_STREAM
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   last_r, last_nxt;
  logic   empty_r, empty_nxt;

  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);

  // Decode the next step
  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    last_nxt      = last_r;
    empty_nxt     = empty_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          if (in_opcode == OP_BYTE) begin
            cmd.take_byte = 1'b1;
          end else if (sts.queue_empty) begin
            cmd.load_empty = 1'b1;
            out_valid_nxt  = 1'b1;
            last_nxt       = 1'b1;
            empty_nxt      = 1'b1;
          end else begin
            cmd.rd_len = 1'b1;
            state_nxt  = ST_LEN;
          end
        end
      end
      ST_LEN: begin
        state_nxt = ST_STREAM;
      end
      ST_STREAM: begin
        // advance one character whenever the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.rd_char   = 1'b1;
          out_valid_nxt = 1'b1;
          last_nxt      = sts.last_char;
          empty_nxt     = 1'b0;
          if (sts.last_char) begin
            cmd.pop_done = 1'b1;
            state_nxt    = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state and result flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      last_r      <= 1'b0;
      empty_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      last_r      <= last_nxt;
      empty_r     <= empty_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_char_last   = last_r;
  assign out_queue_empty = empty_r;

  // Checks
  a_rd_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_char |-> (!out_valid_r || out_ready))
    else $error("character read would overwrite a waiting result");
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && empty_r) |-> last_r)
    else $error("empty reply without last flag");
  a_pop_end: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop_done |=> (state_r == ST_IDLE) && out_valid_r && last_r)
    else $error("pop finished without a final character");

endmodule

// ===== rtl/core/serial_command_line_queue_top.sv =====
// ----------------------------------------------------------------------------
// serial_command_line_queue_top
// Frames received serial bytes into command lines, queues them in a ring of
// line slots that drops the oldest line when full, and streams the oldest
// line out one character per result on a pop.
//
//   Channel | Direction | Handshake          | Payload
//   --------+-----------+--------------------+---------------------------------
//   in_     | input     | in_valid/in_ready  | in_opcode, in_rx_byte
//   out_    | output    | out_valid/out_ready| out_line_char, out_char_last,
//           |           |                    | out_queue_empty
//
// A pop of an empty queue gives its single result the cycle after acceptance.
// A pop of a line first reads the slot length, then reads one character per
// cycle while the output is not stalled, through the single read port of the
// slot memory.
// Reset is synchronous and active low; no memory clearing pass is needed.
// A stalled output holds its result and pauses the character reads; input is
// taken again once the pop finishes and the output register is free.
// ----------------------------------------------------------------------------
module serial_command_line_queue_top #(
  parameter int LINE_CAPACITY = scq_pkg::LINE_CAPACITY_DEF,
  parameter int QUEUE_SLOTS   = scq_pkg::QUEUE_SLOTS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_opcode,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_line_char,
  output logic       out_char_last,
  output logic       out_queue_empty
);
  import scq_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Datapath: framing, ring, memories
  scq_datapath #(
    .LINE_CAPACITY (LINE_CAPACITY),
    .QUEUE_SLOTS   (QUEUE_SLOTS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .rx_byte   (in_rx_byte),
    .sts       (sts),
    .line_char (out_line_char)
  );

  // Controller: handshakes and pop sequencing
  scq_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_char_last   (out_char_last),
    .out_queue_empty (out_queue_empty),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule
